// ===== rtl/dprt_pkg.sv =====
// Package for the dirty page range tracker: operation codes, sequencer
// states and the address width. No dependencies.
`default_nettype none
package dprt_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_TRUNCATE = 2'd1,
    OP_MARK     = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SET_OLD,
    ST_SET_NEW,
    ST_TRIM,
    ST_READ,
    ST_DONE
  } state_t;

  localparam int unsigned ADDR_W = 24;

endpackage
`default_nettype wire

// ===== rtl/dprt_store.sv =====
// Bitmap store of the dirty page range tracker: one synchronous memory of
// page bytes with a registered read port. Depends on nothing else.
`default_nettype none
module dprt_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/dirty_page_range_tracker.sv =====
// Dirty page range tracker: holds one merged byte range until a disjoint
// write, then a page bitmap in a synchronous store. After reset a clearing
// pass writes every store byte, one a cycle, with busy high. A word is taken
// when start is high and busy low. Its result sits on the outputs for the
// one cycle that done is high, and the receiver cannot hold it off. Every
// word runs its work, then raises done, then returns to idle before the next
// word is taken. A range-mode write or truncate has no work and goes straight
// to done. A read goes through a store read state; an out-of-store read goes
// straight to done. Bitmap work runs as passes over store bytes. Each byte
// is read and then written back, and an empty pass writes nothing. A mark is
// one byte. A bitmap-mode write is a trim pass from the first page at or past
// the new file length to the end of the store, empty unless the length shrank,
// then a pass over its own pages. A bitmap truncate is the trim pass and then
// an empty pass. The switch to bitmap mode is a full clearing pass, then the
// passes over the old range and the new one.
`default_nettype none
module dirty_page_range_tracker #(
  parameter int unsigned PAGE_BITS = 12,
  parameter int unsigned MAP_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [23:0] range_first,
  input  wire logic [23:0] range_last,
  input  wire logic [23:0] file_length,
  input  wire logic [11:0] page_number,
  input  wire logic [8:0]  byte_number,
  output logic             done,
  output logic             in_bitmap_mode,
  output logic             held_valid,
  output logic [23:0]      held_first,
  output logic [23:0]      held_last,
  output logic [7:0]       read_byte,
  output logic             overflow
);
  import dprt_pkg::*;

  localparam int unsigned AW  = $clog2(MAP_BYTES);
  localparam int unsigned CAP = MAP_BYTES * 8;
  localparam int unsigned PW  = 25 - PAGE_BITS; // page index incl. carry
  localparam int unsigned CW  = $clog2(CAP) + 1;

  state_t state, state_next;

  logic              bitmap_active, range_present;
  logic [ADDR_W-1:0] range_low, range_high, recorded_length;
  logic [AW-1:0]     in_byte;
  logic              over;
  logic [7:0]        rd_hold;

  // pass bounds: pages [s, e)
  logic [CW-1:0] old_s, old_e, new_s, new_e, trim_s;
  logic [CW-1:0] ps, pe;
  logic [AW-1:0] cur;
  logic          phase;     // 0 issue read, 1 write back

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic          overlap, switch_now, cap_hit_last, cap_hit_high;
  logic          mark_ok, read_ok;
  logic [CW-1:0] trim_start, mark_page;
  logic          acc_over;
  logic [CW-1:0] acc_new_s, acc_new_e;
  logic [AW-1:0] acc_cur;

  logic [7:0]    mask;
  logic [AW-1:0] last_byte;
  logic          pass_empty, pass_end;

  dprt_store #(.DEPTH(MAP_BYTES), .AW(AW)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  function automatic logic [CW-1:0] clampcap(input logic [PW-1:0] p);
    if (32'(p) > CAP) return CW'(CAP);
    return CW'(p);
  endfunction

  function automatic logic [PW-1:0] pfloor(input logic [23:0] o);
    return PW'(o >> PAGE_BITS);
  endfunction

  function automatic logic [PW-1:0] pceil(input logic [23:0] o);
    logic [24:0] s;
    s = {1'b0, o} + 25'((1 << PAGE_BITS) - 1);
    return PW'(s >> PAGE_BITS);
  endfunction

  function automatic logic [AW-1:0] sbyte(input logic [CW-1:0] s);
    return AW'(s >> 3);
  endfunction

  assign overlap      = (range_first <= range_high) && (range_last >= range_low);
  assign switch_now   = !bitmap_active && range_present && !overlap;
  assign cap_hit_last = 32'(pceil(range_last)) > CAP;
  assign cap_hit_high = 32'(pceil(range_high)) > CAP;
  assign mark_ok      = 32'(page_number) < CAP;
  assign read_ok      = 32'(byte_number) < MAP_BYTES;
  assign mark_page    = CW'(page_number);
  assign trim_start   = (file_length < recorded_length) ? clampcap(pceil(file_length))
                                                        : CW'(CAP);

  always_comb begin
    acc_over  = 1'b0;
    acc_new_s = '0;
    acc_new_e = '0;
    acc_cur   = sbyte(trim_start);
    unique case (op_t'(mode))
      OP_WRITE: begin
        acc_over  = cap_hit_last || (switch_now && cap_hit_high);
        acc_new_s = clampcap(pfloor(range_first));
        acc_new_e = clampcap(pceil(range_last));
        if (switch_now) acc_cur = '0;
      end
      OP_TRUNCATE: ;
      OP_MARK: begin
        acc_cur = AW'(page_number >> 3);
        if (mark_ok) begin
          acc_new_s = mark_page;
          acc_new_e = mark_page + CW'(1);
        end else begin
          acc_over = 1'b1;
        end
      end
      default: acc_over = !read_ok;
    endcase
  end

  always_comb begin
    case (state)
      ST_SET_OLD: begin
        ps = old_s;
        pe = old_e;
      end
      ST_TRIM: begin
        ps = trim_s;
        pe = CW'(CAP);
      end
      default: begin
        ps = new_s;
        pe = new_e;
      end
    endcase
  end

  // mask for byte cur of pages [ps, pe), MSB first
  always_comb begin
    for (int i = 0; i < 8; i++) begin : g_bit
      logic [CW-1:0] p;
      p = {1'b0, cur, 3'(i)};
      mask[7-i] = (p >= ps) && (p < pe);
    end
  end

  assign pass_empty = (ps >= pe);
  assign last_byte  = AW'((pe - CW'(1)) >> 3);
  assign pass_end   = pass_empty || (phase && (cur == last_byte));

  assign raddr = (state == ST_READ) ? in_byte : cur;
  assign waddr = cur;

  always_comb begin
    we = 1'b0;
    wdata = 8'h00;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (phase && !pass_empty && (state == ST_SET_OLD || state == ST_SET_NEW ||
                                          state == ST_TRIM)) begin
      we = 1'b1;
      wdata = (state == ST_TRIM) ? (rdata & ~mask) : (rdata | mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    unique case (state)
      ST_IDLE: if (start) begin
        unique case (op_t'(mode))
          OP_WRITE: begin
            if (bitmap_active) state_next = ST_TRIM;
            else if (switch_now) state_next = ST_CLEAR;
            else state_next = ST_DONE;
          end
          OP_TRUNCATE: state_next = bitmap_active ? ST_TRIM : ST_DONE;
          OP_MARK:     state_next = ST_SET_NEW;
          default:     state_next = read_ok ? ST_READ : ST_DONE;
        endcase
      end
      ST_CLEAR: if (cur == AW'(MAP_BYTES - 1)) begin
        state_next = bitmap_active ? ST_SET_OLD : ST_IDLE;
      end
      ST_SET_OLD,
      ST_TRIM:    if (pass_end) state_next = ST_SET_NEW;
      ST_SET_NEW: if (pass_end) state_next = ST_DONE;
      ST_READ:    if (phase) state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_active <= 1'b0; range_present <= 1'b0;
      range_low <= '0; range_high <= '0; recorded_length <= '0;
      cur <= '0; phase <= 1'b0; over <= 1'b0; rd_hold <= '0; in_byte <= '0;
      old_s <= '0; old_e <= '0; new_s <= '0; new_e <= '0; trim_s <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (start) begin
          in_byte <= AW'(byte_number);
          rd_hold <= '0;
          phase   <= 1'b0;
          over    <= acc_over;
          new_s   <= acc_new_s;
          new_e   <= acc_new_e;
          trim_s  <= trim_start;
          cur     <= acc_cur;
          old_s   <= clampcap(pfloor(range_low));
          old_e   <= clampcap(pceil(range_high));
          unique case (op_t'(mode))
            OP_WRITE: begin
              if (bitmap_active) begin
                recorded_length <= file_length;
              end else if (!range_present) begin
                range_present <= 1'b1; range_low <= range_first;
                range_high <= range_last;
              end else if (overlap) begin
                if (range_first < range_low) range_low <= range_first;
                if (range_last > range_high) range_high <= range_last;
              end else begin
                bitmap_active <= 1'b1; range_present <= 1'b0;
                range_low <= '0; range_high <= '0; recorded_length <= file_length;
              end
            end
            OP_TRUNCATE: begin
              if (bitmap_active) begin
                recorded_length <= file_length;
              end else if (range_present) begin
                if (range_low >= file_length) begin
                  range_present <= 1'b0; range_low <= '0; range_high <= '0;
                end else if (range_high > file_length) begin
                  range_high <= file_length;
                end
              end
            end
            default: ;
          endcase
        end
        ST_CLEAR: cur <= (state_next == ST_CLEAR) ? cur + AW'(1) : sbyte(old_s);
        ST_SET_OLD,
        ST_SET_NEW,
        ST_TRIM: begin
          if (pass_end) begin
            cur <= sbyte(new_s);
            phase <= 1'b0;
          end else if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            cur <= cur + AW'(1);
          end
        end
        ST_READ: begin
          phase <= ~phase;
          if (phase) rd_hold <= rdata;
        end
        default: ;
      endcase
    end
  end

  assign in_bitmap_mode = bitmap_active;
  assign held_valid     = range_present;
  assign held_first     = range_low;
  assign held_last      = range_high;
  assign read_byte      = rd_hold;
  assign overflow       = over;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy);
  a_take:      assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy);
  a_pulse:     assert property (@(posedge clk) disable iff (rst) done |=> !done);
  a_mode:      assert property (@(posedge clk) disable iff (rst)
                                in_bitmap_mode |-> !held_valid);
endmodule
`default_nettype wire
